@@ rtl/drs_pkg.sv @@
// Shared constants, register indexes and types for the directory record name search.
package drs_pkg;

  localparam int SECTOR_BYTES   = 2048;
  localparam int MAX_NAME_CHARS = 32;
  localparam int OFF_W          = $clog2(SECTOR_BYTES);

  localparam int DIR_LEN_W  = 12;
  localparam int NAME_LEN_W = 6;
  localparam int CHAR_REGS  = 4;
  localparam int CFG_DATA_W = 64;
  localparam int NAME_BITS  = CHAR_REGS * CFG_DATA_W;
  localparam int CFG_IDX_W  = 3;

  // Offset compare width: holds both a sector offset and a directory length.
  localparam int CMP_W = (OFF_W + 1 > DIR_LEN_W) ? OFF_W + 1 : DIR_LEN_W;

  localparam logic [DIR_LEN_W-1:0] DIR_LEN_RESET = 12'd2048;

  // Byte positions inside a directory record
  localparam logic [7:0] REC_EXTENT_LO = 8'd2;
  localparam logic [7:0] REC_EXTENT_HI = 8'd5;
  localparam logic [7:0] REC_NAME_LEN  = 8'd32;
  localparam logic [7:0] REC_NAME      = 8'd33;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIR_LEN  = 3'd0,
    CFG_NAME_LEN = 3'd1,
    CFG_CHARS_0  = 3'd2,
    CFG_CHARS_1  = 3'd3,
    CFG_CHARS_2  = 3'd4,
    CFG_CHARS_3  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [DIR_LEN_W-1:0]  dir_len;
    logic [NAME_LEN_W-1:0] tgt_len;
    logic [NAME_BITS-1:0]  name_chars;   // char 0 in the low byte
  } cfg_t;

endpackage

@@ rtl/drs_cfg.sv @@
// Configuration register file for the directory record name search.
module drs_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [drs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [drs_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output drs_pkg::cfg_t                    cfg
);
  import drs_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dir_len    <= DIR_LEN_RESET;
      cfg_r.tgt_len    <= '0;
      cfg_r.name_chars <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DIR_LEN:  cfg_r.dir_len <= cfg_wdata[DIR_LEN_W-1:0];
        CFG_NAME_LEN: cfg_r.tgt_len <= cfg_wdata[NAME_LEN_W-1:0];
        CFG_CHARS_0:  cfg_r.name_chars[0*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
        CFG_CHARS_1:  cfg_r.name_chars[1*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
        CFG_CHARS_2:  cfg_r.name_chars[2*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
        CFG_CHARS_3:  cfg_r.name_chars[3*CFG_DATA_W +: CFG_DATA_W] <= cfg_wdata;
        default: ;   // unused index, write dropped
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/directory_record_name_search.sv @@
// Top level: directory sector byte walker and record name matcher.
// The deciding sector byte is registered in the input stage, and its result beat in the result register.
// One sector byte per cycle unless a result beat stalls; the single compare stage
//   between the input register and the result register sets this rate.
// At most one result beat per sector; bytes after a decision produce nothing.
// Reset (rst_n low, synchronous) clears both stages, loads register defaults and
//   leaves the walker waiting for a sector start.
module directory_record_name_search (
  input  logic                             clk,
  input  logic                             rst_n,
  // sector byte stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] sector_byte
  input  logic                             in_tuser,   // [0] sector_start
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [31:0]                      out_tdata,  // [31:0] extent_block
  output logic                             out_tuser,  // [0] found
  // configuration writes
  input  logic                             cfg_we,
  input  logic [drs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [drs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import drs_pkg::*;

  cfg_t cfg;

  drs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // ---------------------------------------------------------------
  // Input register stage
  // ---------------------------------------------------------------
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;

  // result register stage
  logic        out_valid_r;
  logic        out_found_r;
  logic [31:0] out_block_r;

  logic advance;   // result register can take a new value this cycle
  logic fire;      // the registered byte gets processed this cycle

  assign advance   = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && advance;
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_byte_r  <= in_tdata;
      s1_start_r <= in_tuser;
    end
  end

  // ---------------------------------------------------------------
  // Walker state
  //   rel_r tracks the byte position inside the current record; it
  //   never passes the record size, so 8 bits cover it.
  // ---------------------------------------------------------------
  logic [OFF_W-1:0] off_r,  off_nxt;
  logic [7:0]       rel_r,  rel_nxt;
  logic [7:0]       size_r, size_nxt;
  logic [31:0]      acc_r,  acc_nxt;
  logic             mis_r,  mis_nxt;
  logic             decided_r, decided_nxt;

  // values after a sector start is applied
  logic [OFF_W-1:0] off_e;
  logic [7:0]       rel_b, rel_e, size_e;
  logic             dec_e;

  assign off_e  = s1_start_r ? '0 : off_r;
  assign rel_b  = s1_start_r ? '0 : rel_r;
  assign size_e = s1_start_r ? '0 : size_r;
  assign dec_e  = s1_start_r ? 1'b0 : decided_r;

  // record ends exactly here: next record starts at this byte
  assign rel_e = (rel_b == size_e) ? 8'd0 : rel_b;

  // Past the directory: offsets never reach the sector size, so comparing
  // against the raw length gives the same answer as the saturated one.
  logic past_dir;
  assign past_dir = CMP_W'(off_e) >= CMP_W'(cfg.dir_len);

  logic       sector_last;
  assign sector_last = off_e >= OFF_W'(SECTOR_BYTES - 1);

  logic       len_ok;
  logic [7:0] name_end;   // record byte of the last name character
  assign len_ok   = {26'd0, cfg.tgt_len} <= 32'(MAX_NAME_CHARS);
  assign name_end = REC_NAME_LEN + {2'b00, cfg.tgt_len};

  logic [4:0] char_idx;
  logic [7:0] char_sel;
  logic [7:0] rel_name;
  assign rel_name = rel_e - REC_NAME;
  assign char_idx = rel_name[4:0];
  assign char_sel = cfg.name_chars[{char_idx, 3'b000} +: 8];

  logic [7:0] rel_ext;
  assign rel_ext = rel_e - REC_EXTENT_LO;

  logic emit, hit, mis_v;

  always_comb begin
    off_nxt     = off_r;
    rel_nxt     = rel_r;
    size_nxt    = size_r;
    acc_nxt     = acc_r;
    mis_nxt     = mis_r;
    decided_nxt = decided_r;
    mis_v       = mis_r;
    emit        = 1'b0;
    hit         = 1'b0;

    if (fire) begin
      off_nxt     = off_e;
      rel_nxt     = rel_e;
      size_nxt    = size_e;
      decided_nxt = dec_e;

      if (!dec_e) begin
        priority if (rel_e == 8'd0) begin
          // record header: zero size or past the directory ends the scan
          if (past_dir || s1_byte_r == 8'd0) begin
            emit = 1'b1;
          end else begin
            size_nxt = s1_byte_r;
            acc_nxt  = '0;
            // too short to hold the whole name counts as a mismatch
            mis_v    = !len_ok || (s1_byte_r <= name_end);
          end
        end else if (rel_e >= REC_EXTENT_LO && rel_e <= REC_EXTENT_HI) begin
          acc_nxt = acc_r | ({24'd0, s1_byte_r} << {rel_ext[1:0], 3'b000});
        end else if (rel_e == REC_NAME_LEN) begin
          if (s1_byte_r != {2'b00, cfg.tgt_len}) mis_v = 1'b1;
          // empty target matches on the length byte alone
          if (cfg.tgt_len == '0 && !mis_v) begin
            emit = 1'b1;
            hit  = 1'b1;
          end
        end else if (rel_e >= REC_NAME && rel_e <= name_end && len_ok) begin
          if (s1_byte_r != char_sel) mis_v = 1'b1;
          if (rel_e == name_end && !mis_v) begin
            emit = 1'b1;
            hit  = 1'b1;
          end
        end else begin
          // bytes of no interest
        end

        mis_nxt = mis_v;

        // last byte of the sector closes the scan
        if (!emit && sector_last) emit = 1'b1;

        if (emit) begin
          decided_nxt = 1'b1;
        end else begin
          off_nxt = off_e + OFF_W'(1);
          rel_nxt = rel_e + 8'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r     <= '0;
      rel_r     <= '0;
      size_r    <= '0;
      acc_r     <= '0;
      mis_r     <= 1'b0;
      decided_r <= 1'b1;
    end else begin
      off_r     <= off_nxt;
      rel_r     <= rel_nxt;
      size_r    <= size_nxt;
      acc_r     <= acc_nxt;
      mis_r     <= mis_nxt;
      decided_r <= decided_nxt;
    end
  end

  // ---------------------------------------------------------------
  // Result register: holds a beat until the sink takes it
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_found_r <= hit;
      out_block_r <= hit ? acc_r : 32'd0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = out_block_r;

endmodule

@@ rtl/drs_chk.sv @@
// Port-level checker for the directory record name search, bound to the top level.
module drs_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [31:0]                    out_tdata,
  input logic                           out_tuser
);
  import drs_pkg::*;

  // stalled result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // not found always carries a zero block number
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == 32'd0)
    else $error("not-found beat with nonzero block");

  // reset empties the result register
  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a sink that is ready never throttles the byte stream
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while sink ready");

endmodule

bind directory_record_name_search drs_chk u_drs_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ verif/drs_tb_pkg.sv @@
// Scoreboard for the directory record name search: walks sector bytes and holds predicted results.
package drs_tb_pkg;
  import drs_pkg::*;

  typedef struct packed {
    logic        found;
    logic [31:0] extent;
  } search_result_t;

  class sector_scoreboard;
    // register mirror
    int unsigned      dir_len_q;
    int unsigned      tgt_len_q;
    logic [CFG_DATA_W-1:0] chars_q [CHAR_REGS];
    // record walker
    int unsigned      offset_q;
    int unsigned      rec_start_q;
    int unsigned      rec_size_q;
    logic [31:0]      extent_acc;
    bit               mismatch_q;
    bit               decided_q;
    search_result_t   expected_q [$];
    int               errors;
    int               results_seen;

    function new();
      dir_len_q = DIR_LEN_RESET;
      tgt_len_q = 0;
      foreach (chars_q[i]) chars_q[i] = '0;
      offset_q = 0;
      rec_start_q = 0;
      rec_size_q = 0;
      extent_acc = '0;
      mismatch_q = 1'b0;
      decided_q = 1'b1;
      errors = 0;
      results_seen = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_DIR_LEN:  dir_len_q = val[DIR_LEN_W-1:0];
        CFG_NAME_LEN: tgt_len_q = val[NAME_LEN_W-1:0];
        CFG_CHARS_0, CFG_CHARS_1, CFG_CHARS_2, CFG_CHARS_3:
          chars_q[idx - CFG_CHARS_0] = val;
        default: ;
      endcase
    endfunction

    function logic [7:0] char_at(int unsigned j);
      return chars_q[(j >> 3) & 3][8 * (j & 7) +: 8];
    endfunction

    function void post(bit hit);
      search_result_t r;
      r.found = hit;
      r.extent = hit ? extent_acc : '0;
      expected_q.push_back(r);
      decided_q = 1'b1;
    endfunction

    // Advance the walker by one accepted byte; returns 0 when the byte is ignored.
    function bit note_byte(logic [7:0] b, logic start);
      int unsigned lim;
      int unsigned rel;
      if (start) begin
        decided_q = 1'b0;
        offset_q = 0;
        rec_start_q = 0;
        rec_size_q = 0;
      end
      if (decided_q) return 1'b0;
      lim = (dir_len_q > SECTOR_BYTES) ? SECTOR_BYTES : dir_len_q;
      rel = offset_q - rec_start_q;
      if (rel == rec_size_q) begin
        rec_start_q = offset_q;
        rel = 0;
      end
      if (rel == 0) begin
        if (offset_q >= lim || b == 8'd0) begin
          post(1'b0);
          return 1'b1;
        end
        rec_size_q = b;
        extent_acc = '0;
        // records too short to hold the full name never match
        mismatch_q = (tgt_len_q > MAX_NAME_CHARS) || (rec_size_q < REC_NAME + tgt_len_q);
      end else if (rel >= REC_EXTENT_LO && rel <= REC_EXTENT_HI) begin
        extent_acc |= 32'(b) << (8 * (rel - REC_EXTENT_LO));
      end else if (rel == REC_NAME_LEN) begin
        if (b != tgt_len_q) mismatch_q = 1'b1;
        if (tgt_len_q == 0 && !mismatch_q) begin
          post(1'b1);
          return 1'b1;
        end
      end else if (rel >= REC_NAME && rel <= REC_NAME_LEN + tgt_len_q &&
                   tgt_len_q <= MAX_NAME_CHARS) begin
        if (b != char_at(rel - REC_NAME)) mismatch_q = 1'b1;
        if (rel == REC_NAME_LEN + tgt_len_q && !mismatch_q) begin
          post(1'b1);
          return 1'b1;
        end
      end
      if (offset_q >= SECTOR_BYTES - 1) begin
        post(1'b0);
        return 1'b1;
      end
      offset_q++;
      return 1'b1;
    endfunction

    function void check_result(logic found, logic [31:0] extent);
      search_result_t exp;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result beat: expected none, actual found=%0b extent=%h",
                 $time, found, extent);
        return;
      end
      exp = expected_q.pop_front();
      if (found !== exp.found) begin
        errors++;
        $display("%0t: found mismatch: expected %0b, actual %0b", $time, exp.found, found);
      end
      if (extent !== exp.extent) begin
        errors++;
        $display("%0t: extent_block mismatch: expected %h, actual %h",
                 $time, exp.extent, extent);
      end
    endfunction
  endclass

endpackage

@@ verif/tb_top.sv @@
// Testbench top: drives directory sectors into the name search and checks each result beat.
module tb_top;
  import drs_pkg::*;
  import drs_tb_pkg::*;

  localparam int RANDOM_BEATS = 1300;     // live sector bytes in the random part
  localparam int HOLD_CYCLES  = 500;      // long receiver stall to back up the pipe
  localparam int CYCLE_LIMIT  = 300000;
  localparam int NUM_IDX      = 1 << CFG_IDX_W;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [31:0]           out_tdata;
  logic                  out_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sector_scoreboard sb = new();

  logic [7:0]            sector_q [$];        // bytes of the sector being built
  logic [CFG_DATA_W-1:0] reg_vals [NUM_IDX];  // values for the next register program
  int                    live_beats;          // accepted bytes that the walker did not ignore
  int                    cycles;
  int                    gap_rate;            // 1-in-N chance of a sender gap, 0 = none
  bit                    quiet_q;             // tail of the run: no idling on either side
  bit                    hold_req;            // ask the receiver for one long stall

  directory_record_name_search u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sample both handshakes at the rising edge. A result always trails its deciding byte, which
  // passes the input register and then the result register, so the order of the two checks here does not matter.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) sb.check_result(out_tuser, out_tdata);
      if (in_tvalid && in_tready) begin
        if (sb.note_byte(in_tdata, in_tuser)) live_beats++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Receiver: random stall bursts, ready stretches in between, and one long hold
  // when asked. Each pass sets out_tready once and then waits on the falling edge.
  initial begin
    int held;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        for (held = 1; held < HOLD_CYCLES; held++) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet_q && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 13)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(0, 19)) @(negedge clk);
      end
    end
  end

  // Offer one byte and hold it until accepted. Called and returns at a falling edge.
  task automatic drive_byte(input logic [7:0] b, input logic start);
    if (!quiet_q && gap_rate != 0 && $urandom_range(1, gap_rate) == 1) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tdata  <= b;
    in_tuser  <= start;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Send the built sector, first byte flagged as sector start; stop once decided.
  task automatic drive_sector();
    int i;
    for (i = 0; i < sector_q.size(); i++) begin
      drive_byte(sector_q[i], i == 0);
      if (sb.decided_q) break;
    end
    sector_q.delete();
  endtask

  // Append one record: size byte, extent, name length byte, then name characters
  // taken from the mirrored target (one of them flipped when bad_char >= 0).
  function automatic void push_record(int size, int len_byte, int bad_char);
    logic [7:0] b;
    int i;
    int pos;
    for (i = 0; i < size; i++) begin
      pos = i - int'(REC_NAME);
      b = 8'($urandom);
      if (i == 0) begin
        b = size[7:0];
      end else if (i == int'(REC_NAME_LEN)) begin
        b = len_byte[7:0];
      end else if (pos >= 0 && pos < len_byte) begin
        if (pos < MAX_NAME_CHARS) b = sb.char_at(pos);
        if (pos == bad_char) b = b ^ 8'($urandom_range(1, 255));
      end else if (i >= int'(REC_EXTENT_LO) && i <= int'(REC_EXTENT_HI)) begin
        case ($urandom_range(0, 3))
          0:       b = 8'h00;
          1:       b = 8'hFF;
          default: ;
        endcase
      end
      sector_q.push_back(b);
    end
  endfunction

  // Fill records so that the last decision point lands on the final sector byte.
  task automatic build_long_sector(input bit hit);
    int tlen;
    int rest;
    int s;
    tlen = sb.tgt_len_q;
    rest = SECTOR_BYTES - 1 - int'(REC_NAME_LEN) - tlen;
    while (rest > 0) begin
      s = (rest > 400) ? 200 : ((rest > 255) ? rest / 2 : rest);
      push_record(s, tlen ^ 8'h80, -1);   // wrong name length, never matches
      rest -= s;
    end
    if (hit) push_record(int'(REC_NAME) + tlen, tlen, -1);
    else if (tlen == 0) push_record(int'(REC_NAME), 1, -1);
    else push_record(int'(REC_NAME) + tlen, tlen, tlen - 1);
  endtask

  // Mostly well-formed record chains, some truncated, some pure noise.
  task automatic drive_random_sector();
    int kind;
    int n;
    int r;
    int k;
    int size;
    int len_b;
    int bad;
    int tlen;
    tlen = sb.tgt_len_q;
    kind = $urandom_range(0, 19);
    if (kind < 3) begin
      n = $urandom_range(1, 40);
      repeat (n) sector_q.push_back(8'($urandom));
    end else begin
      n = $urandom_range(1, 3);
      for (r = 0; r < n; r++) begin
        k = $urandom_range(0, 9);
        size = int'(REC_NAME) + tlen + $urandom_range(0, 6);
        len_b = tlen;
        bad = -1;
        case (k)
          0, 1, 2: ;
          3, 4: begin
            if (tlen > 0 && tlen <= MAX_NAME_CHARS) bad = $urandom_range(0, tlen - 1);
            else len_b = tlen ^ 1;
          end
          5: len_b = tlen ^ (1 << $urandom_range(0, 7));
          6, 7: size = $urandom_range(1, int'(REC_NAME_LEN) + tlen);  // too short
          8: size = $urandom_range(1, 6);
          default: begin
            size = $urandom_range(int'(REC_NAME), 255);
            len_b = $urandom_range(0, 255);
          end
        endcase
        push_record(size, len_b, bad);
      end
      if ($urandom_range(0, 1) == 0) sector_q.push_back(8'h00);
      // broken chain: cut it short, the next sector start restarts the walk
      if (kind < 5 && sector_q.size() > 1) begin
        repeat ($urandom_range(1, sector_q.size() - 1)) void'(sector_q.pop_back());
      end
    end
    drive_sector();
    if (sb.decided_q && $urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) drive_byte(8'($urandom), 1'b0);   // ignored
    end
  endtask

  // Write the registers selected by the mask, one per cycle, from reg_vals.
  task automatic program_regs(input logic [NUM_IDX-1:0] which);
    int i;
    for (i = 0; i < NUM_IDX; i++) begin
      if (which[i]) begin
        cfg_we    <= 1'b1;
        cfg_index <= i[CFG_IDX_W-1:0];
        cfg_wdata <= reg_vals[i];
        sb.write_reg(i[CFG_IDX_W-1:0], reg_vals[i]);
        @(negedge clk);
      end
    end
    cfg_we <= 1'b0;
  endtask

  // Drop valid, let every expected result drain, then cover the pipe latency.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic pick_settings();
    int i;
    int k;
    logic [NUM_IDX-1:0] which;
    for (i = 0; i < NUM_IDX; i++) reg_vals[i] = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: reg_vals[CFG_DIR_LEN][DIR_LEN_W-1:0] = '0;
      1: reg_vals[CFG_DIR_LEN][DIR_LEN_W-1:0] = DIR_LEN_W'(SECTOR_BYTES);
      2: reg_vals[CFG_DIR_LEN][DIR_LEN_W-1:0] = '1;    // saturates at the sector size
      3: reg_vals[CFG_DIR_LEN][DIR_LEN_W-1:0] = DIR_LEN_W'($urandom_range(30, 300));
      default: ;
    endcase
    case ($urandom_range(0, 7))
      0, 1, 2, 3: reg_vals[CFG_NAME_LEN][NAME_LEN_W-1:0] = NAME_LEN_W'($urandom_range(0, 8));
      4: reg_vals[CFG_NAME_LEN][NAME_LEN_W-1:0] = NAME_LEN_W'(MAX_NAME_CHARS);
      5: reg_vals[CFG_NAME_LEN][NAME_LEN_W-1:0] = '0;
      6: reg_vals[CFG_NAME_LEN][NAME_LEN_W-1:0] =
           NAME_LEN_W'($urandom_range(MAX_NAME_CHARS + 1, 63));
      default: reg_vals[CFG_NAME_LEN][NAME_LEN_W-1:0] =
                 NAME_LEN_W'($urandom_range(9, MAX_NAME_CHARS - 1));
    endcase
    for (i = CFG_CHARS_0; i <= CFG_CHARS_3; i++) begin
      case ($urandom_range(0, 5))
        0: reg_vals[i] = '0;
        1: reg_vals[i] = '1;
        2: for (k = 0; k < 8; k++) if ($urandom_range(0, 2) == 0) reg_vals[i][8*k +: 8] = '0;
        default: ;
      endcase
    end
    which = ($urandom_range(0, 3) == 0) ? NUM_IDX'($urandom) : '1;
    program_regs(which);
  endtask

  initial begin
    int base_beats;
    int phase;
    int s;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_wdata  = '0;
    live_beats = 0;
    cycles     = 0;
    gap_rate   = 3;
    quiet_q    = 1'b0;
    hold_req   = 1'b0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed part, reset register values first ----
    drive_byte(8'hA5, 1'b0);            // before any sector start: ignored
    drive_byte(8'h00, 1'b0);
    sector_q.push_back(8'h00);          // zero record size at the first byte
    drive_sector();
    push_record(int'(REC_NAME), 0, -1); // empty target matches at the length byte
    drive_sector();
    drive_byte(8'hFF, 1'b0);            // after the decision: ignored
    push_record(int'(REC_NAME_LEN), 0, -1);  // one byte too short, then a match
    push_record(40, 0, -1);
    drive_sector();

    // full-length name of all ones, directory length saturating
    wait_idle();
    foreach (reg_vals[i]) reg_vals[i] = '1;
    reg_vals[CFG_NAME_LEN] = CFG_DATA_W'(MAX_NAME_CHARS);
    program_regs('1);
    push_record(int'(REC_NAME) + MAX_NAME_CHARS, MAX_NAME_CHARS, -1);
    drive_sector();
    push_record(int'(REC_NAME) + MAX_NAME_CHARS, MAX_NAME_CHARS, MAX_NAME_CHARS - 1);
    sector_q.push_back(8'h00);
    drive_sector();

    // name made of zero bytes
    wait_idle();
    for (s = CFG_CHARS_0; s <= CFG_CHARS_3; s++) reg_vals[s] = '0;
    program_regs(NUM_IDX'((1 << CFG_CHARS_0) | (1 << CFG_CHARS_1) | (1 << CFG_CHARS_2) |
                          (1 << CFG_CHARS_3)));
    push_record(70, MAX_NAME_CHARS, -1);
    drive_sector();

    // target longer than the name buffer never matches
    wait_idle();
    reg_vals[CFG_NAME_LEN] = '1;
    program_regs(NUM_IDX'(1 << CFG_NAME_LEN));
    push_record(96, 63, -1);
    sector_q.push_back(8'h00);
    drive_sector();

    // empty directory, then records running into the directory length
    wait_idle();
    reg_vals[CFG_DIR_LEN] = '0;
    program_regs(NUM_IDX'(1 << CFG_DIR_LEN));
    sector_q.push_back(8'd50);
    drive_sector();
    wait_idle();
    reg_vals[CFG_DIR_LEN] = CFG_DATA_W'(40);
    reg_vals[CFG_NAME_LEN] = '0;
    program_regs(NUM_IDX'((1 << CFG_DIR_LEN) | (1 << CFG_NAME_LEN)));
    push_record(40, 1, -1);
    push_record(50, 0, -1);
    drive_sector();

    // restart in the middle of a record
    push_record(60, 0, -1);
    while (sector_q.size() > 20) void'(sector_q.pop_back());
    drive_sector();
    push_record(int'(REC_NAME), 0, -1);
    drive_sector();

    // sector end: a miss and a hit on the last byte
    wait_idle();
    reg_vals[CFG_DIR_LEN] = CFG_DATA_W'(SECTOR_BYTES);
    reg_vals[CFG_NAME_LEN] = CFG_DATA_W'(3);
    reg_vals[CFG_CHARS_0] = {$urandom, $urandom};
    program_regs(NUM_IDX'((1 << CFG_DIR_LEN) | (1 << CFG_NAME_LEN) | (1 << CFG_CHARS_0)));
    build_long_sector(1'b0);
    drive_sector();
    wait_idle();
    reg_vals[CFG_NAME_LEN] = '0;
    program_regs(NUM_IDX'(1 << CFG_NAME_LEN));
    build_long_sector(1'b1);
    drive_sector();

    // ---- random part: new settings every few sectors ----
    base_beats = live_beats;
    phase = 0;
    while (live_beats - base_beats < RANDOM_BEATS) begin
      wait_idle();
      pick_settings();
      if (live_beats - base_beats >= RANDOM_BEATS * 4 / 5) quiet_q = 1'b1;
      case ($urandom_range(0, 2))
        0:       gap_rate = 0;
        1:       gap_rate = 2;
        default: gap_rate = 5;
      endcase
      // one long receiver stall while the sender keeps pushing
      if (phase == 2) hold_req = 1'b1;
      for (s = 0; s < 6; s++) drive_random_sector();
      phase++;
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
